FILE: rtl/core/dip_pkg.sv
// Shared types and constants of the decimal integer parser.
`timescale 1ns / 1ps

package dip_pkg;

   // Result error codes
   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_EMPTY     = 3'd1;
   localparam logic [2:0] ERR_INVALID   = 3'd2;
   localparam logic [2:0] ERR_SIGN      = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW  = 3'd4;
   localparam logic [2:0] ERR_UNDERFLOW = 3'd5;

   // Character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Width mode codes
   localparam logic [1:0] WIDTH_8  = 2'd0;
   localparam logic [1:0] WIDTH_16 = 2'd1;
   localparam logic [1:0] WIDTH_32 = 2'd2;
   localparam logic [1:0] WIDTH_64 = 2'd3;

   // Configuration register indexes
   localparam int         CSR_INDEX_W  = 1;
   localparam int         CSR_DATA_W   = 2;
   localparam logic [0:0] CSR_SIGNED   = 1'd0;
   localparam logic [0:0] CSR_WIDTH    = 1'd1;

   localparam int VALUE_W = 64;
   localparam int ACC_W   = VALUE_W + 4;   // holds 10 * magnitude + digit

   // One classified character as it travels from front to back
   typedef struct packed {
      logic       empty;
      logic       last;
      logic       is_digit;
      logic       is_sign;
      logic       is_minus;
      logic [3:0] digit;
   } chr_type;

   typedef struct packed {
      logic       signed_mode;
      logic [1:0] width_mode;
   } cfg_type;

endpackage

FILE: rtl/core/decimal_integer_parser_unit.sv
// Top level of the streaming decimal string to integer parser.
`timescale 1ns / 1ps

// Takes one ASCII character per item on the req_ stream and returns one result per
// string on the rsp_ stream, on the character marked by req_tlast or on an empty
// marker (req_tuser). The sustained rate is one character per clock unless a string's
// ending item waits for a busy output register: the front end classifies and queues
// each item (QUEUE_DEPTH entries), and the back end applies the times-ten accumulate
// and range check to each item as it leaves the queue. The last character of a string
// is registered in the queue, then its result in an output register, where it waits;
// the block keeps taking characters while a result waits. Results carry 0 in the
// value on any error; the first error in a string wins.
// Configuration registers (csr_): index 0 signed_mode (reset 1), index 1 width_mode
// (reset 2: 0=8, 1=16, 2=32, 3=64 bits). Write them only while the block is idle.
// QUEUE_DEPTH must be at least 2.

module decimal_integer_parser_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   // Character input
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] char_byte
   input  logic                            req_tlast,   // is_last
   input  logic                            req_tuser,   // [0] is_empty
   // Result output
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [71:0]                     rsp_tdata,   // [63:0] value_bits, [66:64] error_code
   // Configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dip_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dip_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic                        signed_ff, signed_in;
   logic [1:0]                  width_ff, width_in;
   dip_pkg::cfg_type            cfg;
   logic                        q_valid, q_ready;
   dip_pkg::chr_type            q_entry;
   logic [dip_pkg::VALUE_W-1:0] rsp_value;
   logic [2:0]                  rsp_error;

   // Configuration writes are always accepted; csr_ready is tied high
   assign csr_ready = 1'b1;

   always_comb begin
      signed_in = signed_ff;
      width_in  = width_ff;
      if (csr_valid) begin
         case (csr_index)
            dip_pkg::CSR_SIGNED: signed_in = csr_data[0];
            dip_pkg::CSR_WIDTH:  width_in  = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_ff <= 1'b1;
         width_ff  <= dip_pkg::WIDTH_32;
      end else begin
         signed_ff <= signed_in;
         width_ff  <= width_in;
      end
   end

   assign cfg.signed_mode = signed_ff;
   assign cfg.width_mode  = width_ff;

   // Accept and classify characters; hold them in a short queue
   dip_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry)
   );

   // Accumulate, range check and hold the result
   dip_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_entry    (q_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_value  (rsp_value),
      .rsp_error  (rsp_error)
   );

   // Pack the result, zero fill to whole bytes
   assign rsp_tdata = {5'b0, rsp_error, rsp_value};

endmodule

FILE: rtl/core/dip_front.sv
// Front end: accept characters, classify them and queue them for the back end.
`timescale 1ns / 1ps

module dip_front #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             req_tlast,
   input  logic             req_tuser,
   output logic             q_valid,
   input  logic             q_ready,
   output dip_pkg::chr_type q_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dip_pkg::chr_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   dip_pkg::chr_type cls;
   logic [7:0]       diff;
   logic             push, pop;

   // Classify the incoming byte
   always_comb begin
      diff         = req_tdata - dip_pkg::CHAR_ZERO;
      cls.empty    = req_tuser;
      cls.last     = req_tlast;
      cls.is_digit = (req_tdata >= dip_pkg::CHAR_ZERO) && (req_tdata <= dip_pkg::CHAR_NINE);
      cls.is_minus = (req_tdata == dip_pkg::CHAR_MINUS);
      cls.is_sign  = (req_tdata == dip_pkg::CHAR_PLUS) || cls.is_minus;
      cls.digit    = diff[3:0];
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_entry    = mem_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

endmodule

FILE: rtl/core/dip_back.sv
// Back end: accumulate digits, check range and hold the result for the output.
`timescale 1ns / 1ps

module dip_back (
   input  logic                          clock,
   input  logic                          reset,
   input  dip_pkg::cfg_type              cfg,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  dip_pkg::chr_type              q_entry,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [dip_pkg::VALUE_W-1:0]   rsp_value,
   output logic [2:0]                    rsp_error
);

   logic [dip_pkg::VALUE_W-1:0] mag_ff, mag_in;
   logic                        neg_ff, neg_in;
   logic                        first_ff, first_in;
   logic                        seen_ff, seen_in;
   logic [2:0]                  perr_ff, perr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dip_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [2:0]                  rsp_error_ff, rsp_error_in;

   logic [dip_pkg::VALUE_W-1:0] umax, limit;
   logic [dip_pkg::ACC_W-1:0]   mag_wide, sum;
   logic                        emits, pop, out_free;

   assign emits    = q_entry.empty || q_entry.last;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_ready  = !emits || out_free;
   assign pop      = q_valid && q_ready;

   // Range limit of the configured width
   always_comb begin
      case (cfg.width_mode)
         dip_pkg::WIDTH_8:  umax = 64'h0000_0000_0000_00FF;
         dip_pkg::WIDTH_16: umax = 64'h0000_0000_0000_FFFF;
         dip_pkg::WIDTH_32: umax = 64'h0000_0000_FFFF_FFFF;
         default:           umax = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      if (cfg.signed_mode) begin
         limit = (umax >> 1) + {{(dip_pkg::VALUE_W-1){1'b0}}, neg_ff};
      end else begin
         limit = umax;
      end
   end

   // Times ten plus digit as shift-add; out of range when it passes the limit
   assign mag_wide = {4'b0, mag_ff};
   assign sum = (mag_wide << 3) + (mag_wide << 1) + {{(dip_pkg::ACC_W-4){1'b0}}, q_entry.digit};

   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      first_in     = first_ff;
      seen_in      = seen_ff;
      perr_in      = perr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      if (pop) begin
         if (q_entry.empty) begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_error_in = dip_pkg::ERR_EMPTY;
            mag_in       = '0;
            neg_in       = 1'b0;
            first_in     = 1'b1;
            seen_in      = 1'b0;
            perr_in      = dip_pkg::ERR_OK;
         end else begin
            first_in = 1'b0;
            if (perr_ff == dip_pkg::ERR_OK) begin
               if (first_ff && q_entry.is_sign) begin
                  if (cfg.signed_mode) begin
                     neg_in = q_entry.is_minus;
                  end else begin
                     perr_in = dip_pkg::ERR_SIGN;
                  end
               end else if (!q_entry.is_digit) begin
                  perr_in = dip_pkg::ERR_INVALID;
               end else if (sum > {4'b0, limit}) begin
                  perr_in = (cfg.signed_mode && neg_ff) ? dip_pkg::ERR_UNDERFLOW
                                                        : dip_pkg::ERR_OVERFLOW;
               end else begin
                  mag_in  = sum[dip_pkg::VALUE_W-1:0];
                  seen_in = 1'b1;
               end
            end
            if (q_entry.last) begin
               rsp_valid_in = 1'b1;
               rsp_error_in = perr_in;
               rsp_value_in = '0;
               if (perr_in == dip_pkg::ERR_OK && !seen_in) begin
                  rsp_error_in = dip_pkg::ERR_INVALID;
               end else if (perr_in == dip_pkg::ERR_OK) begin
                  rsp_value_in = (cfg.signed_mode && neg_in) ? ('0 - mag_in) : mag_in;
               end
               mag_in   = '0;
               neg_in   = 1'b0;
               first_in = 1'b1;
               seen_in  = 1'b0;
               perr_in  = dip_pkg::ERR_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         first_ff     <= 1'b1;
         seen_ff      <= 1'b0;
         perr_ff      <= dip_pkg::ERR_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         first_ff     <= first_in;
         seen_ff      <= seen_in;
         perr_ff      <= perr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_error  = rsp_error_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_error_ff != dip_pkg::ERR_OK) |-> (rsp_value_ff == '0))
      else $error("error result with nonzero value");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_error_ff <= dip_pkg::ERR_UNDERFLOW))
      else $error("undefined error code");

   a_emit: assert property (@(posedge clock) disable iff (reset)
      pop && emits |=> rsp_valid_ff)
      else $error("string end without result");

   a_err_not_first: assert property (@(posedge clock) disable iff (reset)
      (perr_ff != dip_pkg::ERR_OK) |-> !first_ff)
      else $error("pending error at start of string");

endmodule
